// ===== hw/rtl/expression_language_lexer_defines.svh =====
// assertion macros shared by the lexer modules
`ifndef EXPRESSION_LANGUAGE_LEXER_DEFINES_SVH
`define EXPRESSION_LANGUAGE_LEXER_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle as the trigger
`define ELL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define ELL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ELL_ASSERT_SAME(lbl, ante, cons, msg)
`define ELL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/ell_pkg.sv =====
// types, constants and helpers shared by the lexer modules
package ell_pkg;

	localparam int CHAR_W  = 8;
	localparam int KIND_W  = 4;
	localparam int LEN_W   = 8;
	localparam int VALUE_W = 31;
	localparam int LINE_W  = 16;
	localparam int KW_W    = 3;

	localparam int DEF_MAX_TOKEN_LEN = 255;
	localparam int DEF_QUEUE_DEPTH   = 4;

	localparam logic [VALUE_W-1:0] NUM_MAX    = '1;
	localparam logic [LINE_W-1:0]  LINE_MAX   = '1;
	localparam logic [KW_W-1:0]    KW_LEN     = 3'd5;
	localparam logic [KW_W-1:0]    KW_NOMATCH = 3'd7;

	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;

	typedef enum logic [KIND_W-1:0] {
		KIND_NUM     = 4'd0,
		KIND_IDENT   = 4'd1,
		KIND_ASSIGN  = 4'd2,
		KIND_PLUS    = 4'd3,
		KIND_MINUS   = 4'd4,
		KIND_MUL     = 4'd5,
		KIND_DIV     = 4'd6,
		KIND_LPAREN  = 4'd7,
		KIND_RPAREN  = 4'd8,
		KIND_PRINT   = 4'd9,
		KIND_SEMI    = 4'd10,
		KIND_END     = 4'd11,
		KIND_NEWLINE = 4'd12,
		KIND_ERROR   = 4'd13
	} ell_kind_t;

	typedef enum logic [2:0] {
		CLS_END,
		CLS_SPACE,
		CLS_NEWLINE,
		CLS_OP,
		CLS_DIGIT,
		CLS_LETTER,
		CLS_UNDER,
		CLS_OTHER
	} ell_cls_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_IDENT,
		MODE_ERR
	} ell_mode_t;

	typedef struct packed {
		ell_cls_t          cls;
		ell_kind_t         op_kind;
		logic [CHAR_W-1:0] code;
	} ell_entry_t;

	typedef struct packed {
		ell_kind_t          kind;
		logic [LEN_W-1:0]   len;
		logic [VALUE_W-1:0] value;
		logic [LINE_W-1:0]  line;
		logic               last;
	} ell_token_t;

	// letters of the keyword "print"
	function automatic logic [CHAR_W-1:0] kw_char(input logic [KW_W-1:0] pos);
		logic [CHAR_W-1:0] c;
		case (pos)
			3'd0:    c = 8'h70;
			3'd1:    c = 8'h72;
			3'd2:    c = 8'h69;
			3'd3:    c = 8'h6E;
			3'd4:    c = 8'h74;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/ell_front.sv =====
// front end: takes characters and classifies them into queue entries
module ell_front import ell_pkg::*; (
	input  logic [CHAR_W-1:0] char_code,
	input  logic              char_valid,
	output logic              char_stall,
	input  logic              q_full,
	output logic              push,
	output ell_entry_t        push_entry
);

	logic is_digit;
	logic is_letter;

	assign char_stall = q_full;
	assign push       = char_valid && !q_full;

	assign is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
	assign is_letter = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
	                   ((char_code >= 8'h41) && (char_code <= 8'h5A));

	always_comb begin
		push_entry.code    = char_code;
		push_entry.op_kind = KIND_ERROR;
		push_entry.cls     = CLS_OTHER;
		unique case (char_code)
			CH_NUL:           push_entry.cls = CLS_END;
			CH_SPACE, CH_TAB: push_entry.cls = CLS_SPACE;
			CH_LF:            push_entry.cls = CLS_NEWLINE;
			CH_EQUAL: begin
				push_entry.cls     = CLS_OP;
				push_entry.op_kind = KIND_ASSIGN;
			end
			CH_PLUS: begin
				push_entry.cls     = CLS_OP;
				push_entry.op_kind = KIND_PLUS;
			end
			CH_MINUS: begin
				push_entry.cls     = CLS_OP;
				push_entry.op_kind = KIND_MINUS;
			end
			CH_STAR: begin
				push_entry.cls     = CLS_OP;
				push_entry.op_kind = KIND_MUL;
			end
			CH_SLASH: begin
				push_entry.cls     = CLS_OP;
				push_entry.op_kind = KIND_DIV;
			end
			CH_LPAREN: begin
				push_entry.cls     = CLS_OP;
				push_entry.op_kind = KIND_LPAREN;
			end
			CH_RPAREN: begin
				push_entry.cls     = CLS_OP;
				push_entry.op_kind = KIND_RPAREN;
			end
			CH_SEMI: begin
				push_entry.cls     = CLS_OP;
				push_entry.op_kind = KIND_SEMI;
			end
			CH_UNDER:         push_entry.cls = CLS_UNDER;
			default: begin
				if (is_digit) begin
					push_entry.cls = CLS_DIGIT;
				end else if (is_letter) begin
					push_entry.cls = CLS_LETTER;
				end else begin
					push_entry.cls = CLS_OTHER;
				end
			end
		endcase
	end

endmodule

// ===== hw/rtl/ell_queue.sv =====
// small fifo of classified characters between front and back
`include "expression_language_lexer_defines.svh"

module ell_queue import ell_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ell_entry_t push_entry,
	output logic       full,
	output logic       q_valid,
	input  logic       pop,
	output ell_entry_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ell_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ELL_ASSERT_SAME(a_q_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count overflow")
	`ELL_ASSERT_SAME(a_q_pop_nonempty, pop, count_q != '0, "pop from empty queue")
	`ELL_ASSERT_NEXT(a_q_push_lands, push && !pop, count_q != '0, "pushed entry lost")

endmodule

// ===== hw/rtl/ell_back.sv =====
// back end: scanner state, token forming and output register with spill slot
`include "expression_language_lexer_defines.svh"

module ell_back import ell_pkg::*; #(
	parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  ell_entry_t         head,
	output logic               q_pop,
	output logic               token_valid,
	input  logic               token_stall,
	output logic [KIND_W-1:0]  token_kind,
	output logic [LEN_W-1:0]   token_length,
	output logic [VALUE_W-1:0] number_value,
	output logic [LINE_W-1:0]  line_number,
	output logic               last_of_run
);

	ell_mode_t          mode_q, mode_d;
	logic [LEN_W-1:0]   len_q, len_d, len_bump;
	logic [VALUE_W-1:0] acc_q, acc_d, acc_next;
	logic [VALUE_W+3:0] prod;
	logic [KW_W-1:0]    kw_q, kw_d, kw_next;
	logic [LINE_W-1:0]  line_q, line_d;

	ell_token_t out_q, spill_q;
	logic       out_vld_q, spill_vld_q;
	logic       out_free;

	logic       handle;
	logic       run_vld, chr_vld, two;
	ell_token_t run_tok, chr_tok, first_tok, second_tok;

	assign out_free = !out_vld_q || !token_stall;
	assign q_pop    = q_valid && out_free && !spill_vld_q;

	// saturating run arithmetic
	assign len_bump = (len_q < LEN_W'(MAX_TOKEN_LEN)) ? len_q + 1'b1 : len_q;
	assign prod     = ({4'b0000, acc_q} << 3) + ({4'b0000, acc_q} << 1) +
	                  (VALUE_W + 4)'(head.code[3:0]);
	assign acc_next = (prod > (VALUE_W + 4)'(NUM_MAX)) ? NUM_MAX : prod[VALUE_W-1:0];
	assign kw_next  = ((kw_q < KW_LEN) && (head.code == kw_char(kw_q))) ?
	                  kw_q + 1'b1 : KW_NOMATCH;

	always_comb begin
		mode_d  = mode_q;
		len_d   = len_q;
		acc_d   = acc_q;
		kw_d    = kw_q;
		line_d  = line_q;
		handle  = 1'b1;
		run_vld = 1'b0;
		chr_vld = 1'b0;
		run_tok       = '0;
		run_tok.kind  = KIND_NUM;
		run_tok.line  = line_q;
		chr_tok       = '0;
		chr_tok.kind  = KIND_ERROR;
		chr_tok.len   = LEN_W'(1);
		chr_tok.line  = line_q;

		// close or extend the current run
		unique case (mode_q)
			MODE_ERR: handle = (head.cls == CLS_END);
			MODE_NUM: begin
				if (head.cls == CLS_DIGIT) begin
					handle = 1'b0;
					len_d  = len_bump;
					acc_d  = acc_next;
				end else begin
					run_vld       = 1'b1;
					run_tok.kind  = KIND_NUM;
					run_tok.len   = len_q;
					run_tok.value = acc_q;
				end
			end
			MODE_IDENT: begin
				if (head.cls == CLS_DIGIT || head.cls == CLS_LETTER ||
				    head.cls == CLS_UNDER) begin
					handle = 1'b0;
					len_d  = len_bump;
					kw_d   = kw_next;
				end else begin
					run_vld      = 1'b1;
					run_tok.kind = (kw_q == KW_LEN) ? KIND_PRINT : KIND_IDENT;
					run_tok.len  = len_q;
				end
			end
			default: ;
		endcase

		// the character itself, from idle
		if (handle) begin
			mode_d = MODE_IDLE;
			len_d  = '0;
			acc_d  = '0;
			kw_d   = '0;
			unique case (head.cls)
				CLS_END: begin
					chr_vld      = 1'b1;
					chr_tok.kind = KIND_END;
					chr_tok.len  = '0;
					line_d       = LINE_W'(1);
				end
				CLS_SPACE: ;
				CLS_NEWLINE: begin
					chr_vld      = 1'b1;
					chr_tok.kind = KIND_NEWLINE;
					if (line_q != LINE_MAX) begin
						line_d = line_q + 1'b1;
					end
				end
				CLS_OP: begin
					chr_vld      = 1'b1;
					chr_tok.kind = head.op_kind;
				end
				CLS_DIGIT: begin
					mode_d = MODE_NUM;
					len_d  = LEN_W'(1);
					acc_d  = VALUE_W'(head.code[3:0]);
				end
				CLS_LETTER: begin
					mode_d = MODE_IDENT;
					len_d  = LEN_W'(1);
					kw_d   = (head.code == kw_char('0)) ? KW_W'(1) : KW_NOMATCH;
				end
				default: begin
					chr_vld      = 1'b1;
					chr_tok.kind = KIND_ERROR;
					mode_d       = MODE_ERR;
				end
			endcase
		end

		two             = run_vld && chr_vld;
		first_tok       = run_vld ? run_tok : chr_tok;
		first_tok.last  = !two;
		second_tok      = chr_tok;
		second_tok.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= '0;
			acc_q  <= '0;
			kw_q   <= '0;
			line_q <= LINE_W'(1);
		end else if (q_pop) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			acc_q  <= acc_d;
			kw_q   <= kw_d;
			line_q <= line_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			spill_vld_q <= 1'b0;
		end else if (out_free) begin
			if (spill_vld_q) begin
				out_vld_q   <= 1'b1;
				spill_vld_q <= 1'b0;
			end else if (q_pop && (run_vld || chr_vld)) begin
				out_vld_q   <= 1'b1;
				spill_vld_q <= two;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (spill_vld_q) begin
				out_q <= spill_q;
			end else if (q_pop) begin
				out_q   <= first_tok;
				spill_q <= second_tok;
			end
		end
	end

	assign token_valid  = out_vld_q;
	assign token_kind   = out_q.kind;
	assign token_length = out_q.len;
	assign number_value = out_q.value;
	assign line_number  = out_q.line;
	assign last_of_run  = out_q.last;

	`ELL_ASSERT_SAME(a_spill_behind_out, spill_vld_q, out_vld_q, "spill without output")
	`ELL_ASSERT_SAME(a_line_nonzero, 1'b1, line_q != '0, "line count wrapped")
	`ELL_ASSERT_SAME(a_len_bound, 1'b1, len_q <= LEN_W'(MAX_TOKEN_LEN), "run length too big")
	`ELL_ASSERT_NEXT(a_end_resets_line, q_pop && head.cls == CLS_END,
		line_q == LINE_W'(1), "end of input kept line count")

endmodule

// ===== hw/rtl/expression_language_lexer.sv =====
// top level of the expression language lexer
//
// channel   direction  handshake            payload
// char      in         char_valid/stall     char_code
// token     out        token_valid/stall    token_kind, token_length, number_value,
//                                           line_number, last_of_run
//
// one character per cycle is taken while the output keeps up; the front end
// classifies it and the back end scans one queue entry per cycle unless a token is held
// a character that closes a run and emits its own token gives two transactions,
// so the back end holds until the second leaves the spill slot for the single output register
// reset (arst_n low) empties the queue, drops any token and sets line 1, idle
// token_stall holds the output register and spill slot; the queue then fills
// and char_stall rises once all queue entries are taken
module expression_language_lexer import ell_pkg::*; #(
	parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
	parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [CHAR_W-1:0]  char_code,
	output logic               token_valid,
	input  logic               token_stall,
	output logic [KIND_W-1:0]  token_kind,
	output logic [LEN_W-1:0]   token_length,
	output logic [VALUE_W-1:0] number_value,
	output logic [LINE_W-1:0]  line_number,
	output logic               last_of_run
);

	// front to queue
	logic       push;
	ell_entry_t push_entry;
	logic       q_full;

	// queue to back
	logic       q_valid;
	logic       q_pop;
	ell_entry_t head;

	// classify each incoming character transaction
	ell_front u_front (
		.char_code  (char_code),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples character intake from token output
	ell_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.q_valid    (q_valid),
		.pop        (q_pop),
		.head       (head)
	);

	// run tracking, keyword match, number accumulation and token output
	ell_back #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.head         (head),
		.q_pop        (q_pop),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.token_length (token_length),
		.number_value (number_value),
		.line_number  (line_number),
		.last_of_run  (last_of_run)
	);

endmodule
